// ===== design/aorc_pkg.sv =====
// shared types and register indexes for the adc oversample range check
package aorc_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned SumWidth    = 16;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned IndexWidth  = 3;
  localparam int unsigned CfgWidth    = 32;

  typedef enum logic [IndexWidth-1:0] {
    REG_SAMPLES_PER_REPORT = 3'd0,
    REG_MIN_SUM            = 3'd1,
    REG_MAX_SUM            = 3'd2,
    REG_FAULT_LIMIT        = 3'd3,
    REG_START_TIME         = 3'd4,
    REG_REST_INTERVAL      = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CountWidth-1:0] samples_per_report;
    logic [SumWidth-1:0]   min_sum;
    logic [SumWidth-1:0]   max_sum;
    logic [CountWidth-1:0] fault_limit;
    logic [TimeWidth-1:0]  start_time;
    logic [TimeWidth-1:0]  rest_interval;
    logic                  start_load;
  } cfg_t;

  typedef struct packed {
    logic                 range_fault;
    logic [TimeWidth-1:0] report_time;
    logic [SumWidth-1:0]  sum;
  } report_t;

endpackage

// ===== design/aorc_cfg.sv =====
// configuration registers and start time load strobe
module aorc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [aorc_pkg::IndexWidth-1:0] cfg_index,
  input  logic [aorc_pkg::CfgWidth-1:0] cfg_data,
  output aorc_pkg::cfg_t                cfg
);
  import aorc_pkg::*;

  logic [CountWidth-1:0] samples_per_report;
  logic [SumWidth-1:0]   min_sum;
  logic [SumWidth-1:0]   max_sum;
  logic [CountWidth-1:0] fault_limit;
  logic [TimeWidth-1:0]  rest_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_report <= CountWidth'(1);
      min_sum            <= '0;
      max_sum            <= '1;
      fault_limit        <= '0;
      rest_interval      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_REPORT: samples_per_report <= cfg_data[CountWidth-1:0];
        REG_MIN_SUM:            min_sum            <= cfg_data[SumWidth-1:0];
        REG_MAX_SUM:            max_sum            <= cfg_data[SumWidth-1:0];
        REG_FAULT_LIMIT:        fault_limit        <= cfg_data[CountWidth-1:0];
        // start time only acts through the load strobe
        REG_START_TIME:         ;
        REG_REST_INTERVAL:      rest_interval      <= cfg_data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.samples_per_report = samples_per_report;
    cfg.min_sum            = min_sum;
    cfg.max_sum            = max_sum;
    cfg.fault_limit        = fault_limit;
    cfg.start_time         = cfg_data[TimeWidth-1:0];
    cfg.rest_interval      = rest_interval;
    cfg.start_load         = cfg_we && (cfg_index == REG_START_TIME);
  end

endmodule

// ===== design/aorc_in_reg.sv =====
// input register for one sample
module aorc_in_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  logic [aorc_pkg::SampleWidth-1:0] s_data,
  input  logic                             advance,
  output logic                             valid,
  output logic [aorc_pkg::SampleWidth-1:0] sample
);
  import aorc_pkg::*;

  assign s_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      sample <= s_data;
    end
  end

endmodule

// ===== design/aorc_group.sv =====
// group accumulator, window check, bad run counter and report timestamp
module aorc_group (
  input  logic                             clk,
  input  logic                             rst,
  input  aorc_pkg::cfg_t                   cfg,
  input  logic                             valid,
  input  logic [aorc_pkg::SampleWidth-1:0] sample,
  input  logic                             advance,
  output logic                             result_valid,
  output aorc_pkg::report_t                result
);
  import aorc_pkg::*;

  logic [SumWidth-1:0]   accumulator;
  logic [CountWidth-1:0] group_position;
  logic [CountWidth-1:0] bad_run_count;
  logic [TimeWidth-1:0]  group_start_time;

  logic                  enabled;
  logic                  restart;
  logic [SumWidth-1:0]   acc_sum;
  logic [CountWidth-1:0] pos_inc;
  logic                  done;
  logic                  in_range;
  logic [CountWidth-1:0] bad_inc;
  logic                  hit;
  logic [CountWidth-1:0] bad_next;
  logic [TimeWidth-1:0]  time_next;

  always_comb begin
    enabled   = cfg.samples_per_report != '0;
    restart   = group_position >= cfg.samples_per_report;
    acc_sum   = (restart ? '0 : accumulator) + sample;
    pos_inc   = (restart ? '0 : group_position) + CountWidth'(1);
    done      = enabled && (pos_inc >= cfg.samples_per_report);
    in_range  = (acc_sum >= cfg.min_sum) && (acc_sum <= cfg.max_sum);
    bad_inc   = bad_run_count + CountWidth'(1);
    hit       = bad_inc >= cfg.fault_limit;
    bad_next  = (in_range || hit) ? '0 : bad_inc;
    time_next = group_start_time + cfg.rest_interval;

    result_valid       = valid && done;
    result.sum         = acc_sum;
    result.report_time = time_next;
    result.range_fault = !in_range && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator      <= '0;
      group_position   <= '0;
      bad_run_count    <= '0;
      group_start_time <= '0;
    end else if (cfg.start_load) begin
      accumulator      <= '0;
      group_position   <= '0;
      group_start_time <= cfg.start_time;
    end else if (advance && enabled) begin
      if (done) begin
        accumulator      <= '0;
        group_position   <= '0;
        bad_run_count    <= bad_next;
        group_start_time <= time_next;
      end else begin
        accumulator    <= acc_sum;
        group_position <= pos_inc;
      end
    end
  end

endmodule

// ===== design/aorc_out_reg.sv =====
// output register holding one report until its transfer
module aorc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  aorc_pkg::report_t data_in,
  output logic              ready,
  output logic              m_valid,
  input  logic              m_ready,
  output aorc_pkg::report_t data_out
);
  import aorc_pkg::*;

  assign ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ready) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      data_out <= data_in;
    end
  end

endmodule

// ===== design/adc_oversample_range_check.sv =====
// Sums groups of samples_per_report ADC samples into a 16-bit wrapping sum,
// checks each group sum against the inclusive window [min_sum, max_sum] and
// emits one report per completed group with the sum, the group start time
// advanced by rest_interval and a fault flag raised when the run of
// consecutive out-of-range groups reaches fault_limit. One sample is taken
// every cycle unless a completed group waits for a full output register: a
// sample passes an input register, then add, compare and count logic that
// updates the group state and loads the output register, from which the
// report is offered. Input and output are parted by the output register,
// so a sample that completes no group moves on even while a report waits.
// Writing start_time restarts the current group. The user must write
// configuration only while the block is idle; the block does not enforce it.
module adc_oversample_range_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // sum, report_time
  output logic                          m_axis_tuser,  // range_fault
  input  logic                          cfg_we,
  input  logic [aorc_pkg::IndexWidth-1:0] cfg_index,
  input  logic [aorc_pkg::CfgWidth-1:0] cfg_data
);
  import aorc_pkg::*;

  cfg_t                   cfg;
  logic                   in_valid;
  logic [SampleWidth-1:0] in_sample;
  logic                   advance;
  logic                   result_valid;
  report_t                result;
  logic                   out_ready;
  report_t                report;

  aorc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aorc_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .advance (advance),
    .valid   (in_valid),
    .sample  (in_sample)
  );

  aorc_group u_group (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .valid        (in_valid),
    .sample       (in_sample),
    .advance      (advance),
    .result_valid (result_valid),
    .result       (result)
  );

  assign advance = in_valid && (out_ready || !result_valid);

  aorc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && result_valid),
    .data_in  (result),
    .ready    (out_ready),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .data_out (report)
  );

  assign m_axis_tdata = {report.report_time, report.sum};
  assign m_axis_tuser = report.range_fault;

  // a reported fault always comes with a sum outside the window
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (report.sum < cfg.min_sum) || (report.sum > cfg.max_sum))
    else $error("fault reported for an in-range sum");

  // disabled sampling never produces a report
  assert property (@(posedge clk) disable iff (rst)
    in_valid && (cfg.samples_per_report == '0) |-> !result_valid)
    else $error("report with sampling disabled");

  // an empty input register always takes a sample
  assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled while empty");

  // no report is pending right after reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("report pending after reset");

endmodule

// ===== verif/tb.sv =====
// testbench for adc_oversample_range_check: directed and random samples checked by a predictor
module tb;
  import aorc_pkg::*;

  localparam int Limit = 400000;
  localparam int Drain = 8;
  localparam int LongHold = 300;
  localparam logic [IndexWidth-1:0] RegUnused6 = 3'd6;
  localparam logic [IndexWidth-1:0] RegUnused7 = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SampleWidth-1:0] s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [47:0]            m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic [IndexWidth-1:0]  cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_data = '0;

  // predictor copy of registers and group state
  logic [CountWidth-1:0]  cfg_spr, cfg_flim, grp_pos, bad_run;
  logic [SumWidth-1:0]    cfg_min, cfg_max, acc;
  logic [TimeWidth-1:0]   cfg_rest, grp_time;

  logic [SampleWidth-1:0] sample_q[$];
  report_t                report_q[$];
  logic                   in_taken = 1'b0;
  int                     items_in_flight = 0;
  int                     errors = 0;
  int                     cycle_count = 0;
  int                     send_idle = 0;
  int                     recv_stall = 0;
  int                     out_hold_left = 0;
  int                     ph, n;
  int unsigned            spr_v, lo_v, hi_v, flim_v, swap_v;

  adc_oversample_range_check u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void clear_predictor();
    cfg_spr   = 8'd1;
    cfg_min   = '0;
    cfg_max   = '1;
    cfg_flim  = '0;
    cfg_rest  = '0;
    acc       = '0;
    grp_pos   = '0;
    bad_run   = '0;
    grp_time  = '0;
  endfunction

  function automatic void accumulate_sample(logic [SampleWidth-1:0] s);
    report_t r;
    if (cfg_spr == '0) return;
    if (grp_pos >= cfg_spr) begin
      grp_pos = '0;
      acc = '0;
    end
    acc = acc + s;
    grp_pos = grp_pos + 1'b1;
    if (grp_pos < cfg_spr) return;
    r.range_fault = 1'b0;
    if (acc >= cfg_min && acc <= cfg_max) begin
      bad_run = '0;
    end else begin
      bad_run = bad_run + 1'b1;
      if (bad_run >= cfg_flim) begin
        r.range_fault = 1'b1;
        bad_run = '0;
      end
    end
    grp_time = grp_time + cfg_rest;
    r.sum = acc;
    r.report_time = grp_time;
    report_q.push_back(r);
    grp_pos = '0;
    acc = '0;
  endfunction

  function automatic logic [SampleWidth-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SampleWidth'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [IndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SAMPLES_PER_REPORT: cfg_spr = val[CountWidth-1:0];
      REG_MIN_SUM:            cfg_min = val[SumWidth-1:0];
      REG_MAX_SUM:            cfg_max = val[SumWidth-1:0];
      REG_FAULT_LIMIT:        cfg_flim = val[CountWidth-1:0];
      REG_START_TIME: begin
        grp_time = val;
        acc = '0;
        grp_pos = '0;
      end
      REG_REST_INTERVAL:      cfg_rest = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(logic [SampleWidth-1:0] v);
    sample_q.push_back(v);
    items_in_flight++;
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    @(posedge clk);
    send_idle = sender_pct;
    recv_stall = receiver_pct;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (items_in_flight != 0 || report_q.size() != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (out_hold_left != 0) begin
      out_hold_left = out_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // monitor: check report transfers, predict from sample transfers
  always @(posedge clk) begin
    report_t                 want;
    logic [SumWidth-1:0]     got_sum;
    logic [TimeWidth-1:0]    got_time;
    in_taken = s_axis_tvalid && s_axis_tready;
    got_sum = m_axis_tdata[SumWidth-1:0];
    got_time = m_axis_tdata[SumWidth +: TimeWidth];
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, got sum %h time %h fault %b",
                   $time, got_sum, got_time, m_axis_tuser);
        end else begin
          want = report_q.pop_front();
          if (got_sum !== want.sum) begin
            errors++;
            $display("%0t: sum expected %h got %h", $time, want.sum, got_sum);
          end
          if (got_time !== want.report_time) begin
            errors++;
            $display("%0t: report_time expected %h got %h", $time, want.report_time,
                     got_time);
          end
          if (m_axis_tuser !== want.range_fault) begin
            errors++;
            $display("%0t: range_fault expected %b got %b", $time, want.range_fault,
                     m_axis_tuser);
          end
        end
      end
      if (in_taken) begin
        accumulate_sample(s_axis_tdata);
        items_in_flight--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("adc_oversample_range_check: mismatch");
      $finish;
    end
  end

  initial begin
    clear_predictor();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset settings
    send('0);
    send('1);
    wait_idle();

    // window edges, wrapping sum, fault on second bad group, time wrap
    write_reg(REG_SAMPLES_PER_REPORT, 32'd3);
    write_reg(REG_MIN_SUM, 32'd100);
    write_reg(REG_MAX_SUM, 32'd200);
    write_reg(REG_FAULT_LIMIT, 32'd2);
    write_reg(REG_START_TIME, 32'hffff_fff0);
    write_reg(REG_REST_INTERVAL, 32'h0000_0010);
    send(16'hffff); send(16'd2); send(16'hffff);
    send(16'hffff); send(16'd1); send(16'd0);
    send(16'd50);   send(16'd50); send(16'd100);
    send(16'd0);    send(16'd33); send(16'd67);
    wait_idle();

    // minimum above maximum, register extremes, unused indexes
    write_reg(REG_SAMPLES_PER_REPORT, 32'd1);
    write_reg(REG_MIN_SUM, 32'h0000_ffff);
    write_reg(REG_MAX_SUM, 32'd0);
    write_reg(REG_FAULT_LIMIT, 32'd255);
    write_reg(REG_START_TIME, 32'hffff_ffff);
    write_reg(REG_REST_INTERVAL, 32'hffff_ffff);
    write_reg(RegUnused6, 32'hffff_ffff);
    write_reg(RegUnused7, 32'h0000_0000);
    send(16'h1234);
    send(16'h8000);
    wait_idle();
    write_reg(REG_FAULT_LIMIT, 32'd0);
    send(16'h5555);
    wait_idle();

    // sampling disabled, group size lowered mid-group, start_time mid-group
    write_reg(REG_SAMPLES_PER_REPORT, 32'd0);
    send(16'haaaa);
    wait_idle();
    write_reg(REG_MIN_SUM, 32'd1000);
    write_reg(REG_MAX_SUM, 32'd50000);
    write_reg(REG_SAMPLES_PER_REPORT, 32'd4);
    send(16'd300); send(16'd400); send(16'd500);
    wait_idle();
    write_reg(REG_SAMPLES_PER_REPORT, 32'd2);
    send(16'd700); send(16'd800);
    wait_idle();
    write_reg(REG_SAMPLES_PER_REPORT, 32'd3);
    send(16'd999);
    wait_idle();
    write_reg(REG_START_TIME, 32'h1234_5678);
    send(16'd1); send(16'd2); send(16'd3);
    wait_idle();

    // largest group
    write_reg(REG_SAMPLES_PER_REPORT, 32'd255);
    write_reg(REG_REST_INTERVAL, $urandom);
    repeat (255) send(pick_sample());
    wait_idle();

    // output held off while the sender keeps offering
    write_reg(REG_SAMPLES_PER_REPORT, 32'd1);
    @(posedge clk);
    out_hold_left = LongHold;
    repeat (40) send(pick_sample());
    wait_idle();

    for (ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(77, 0);
        2: set_idling(0, 77);
        default: set_idling(6, 6);
      endcase
      if (ph % 5 == 4) begin
        // noise while sampling is off
        write_reg(REG_SAMPLES_PER_REPORT, $urandom << CountWidth);
        repeat (10) send(pick_sample());
        wait_idle();
      end
      spr_v = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      lo_v = $urandom_range(0, 65535);
      hi_v = lo_v + $urandom_range(0, 40000);
      if (hi_v > 65535) hi_v = 65535;
      if ($urandom_range(0, 5) == 0) begin
        swap_v = lo_v;
        lo_v = hi_v;
        hi_v = swap_v;
      end
      flim_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      write_reg(REG_SAMPLES_PER_REPORT, ($urandom << CountWidth) | spr_v);
      write_reg(REG_MIN_SUM, ($urandom << SumWidth) | lo_v);
      write_reg(REG_MAX_SUM, ($urandom << SumWidth) | hi_v);
      write_reg(REG_FAULT_LIMIT, ($urandom << CountWidth) | flim_v);
      write_reg(REG_START_TIME, $urandom);
      write_reg(REG_REST_INTERVAL, $urandom);
      if (spr_v > 1 && $urandom_range(0, 2) == 0) begin
        // broken group: restart or resize part way through
        repeat ($urandom_range(1, spr_v - 1)) send(pick_sample());
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_START_TIME, $urandom);
        end else begin
          spr_v = $urandom_range(1, 6);
          write_reg(REG_SAMPLES_PER_REPORT, spr_v);
        end
      end
      n = 0;
      while (n < 22) begin
        repeat (spr_v) send(pick_sample());
        n += spr_v;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("adc_oversample_range_check: match");
    end else begin
      $display("adc_oversample_range_check: mismatch");
    end
    $finish;
  end

endmodule
